// ===== sv/stack_with_search_defines.svh =====
// Assertion macros for the stack_with_search RTL, included by sws_ctrl.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef STACK_WITH_SEARCH_DEFINES_SVH
`define STACK_WITH_SEARCH_DEFINES_SVH

// Check a condition on every clock edge outside reset.
`define SWS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define SWS_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ===== sv/sws_pkg.sv =====
// Shared types and constants for the stack_with_search block.
// No dependencies; used by sws_mem, sws_ctrl and stack_with_search.
`default_nettype none

package sws_pkg;

  localparam int WORD_W     = 32;
  localparam int OPCODE_W   = 2;
  localparam int POS_W      = 7;
  localparam int STATUS_W   = 2;
  localparam int OUT_DATA_W = 40;  // result_value + position, padded to bytes

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam opcode_t OP_PUSH   = 2'd0;
  localparam opcode_t OP_POP    = 2'd1;
  localparam opcode_t OP_PEEK   = 2'd2;
  localparam opcode_t OP_SEARCH = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_UNDERFLOW = 2'd1;
  localparam status_t ST_OVERFLOW  = 2'd2;
  localparam status_t ST_NOT_FOUND = 2'd3;

endpackage

`default_nettype wire

// ===== sv/stack_with_search.sv =====
// Channel  Signals                          Beat contents
// s        s_tvalid s_tready s_tdata s_tuser request: operand, opcode
// m        m_tvalid m_tready m_tdata m_tuser result: result_value, position, status
//
// Push, and any request that fails at once, goes from accept to the done state, then to the result.
// Pop and peek add one memory read of the top entry, in the read state, before the done state.
// Search reads one entry per cycle from the top until it matches or reaches the bottom entry,
// a rate set by the single memory read port.
// Reset (rst, synchronous) empties the stack; storage is not cleared.
// A stalled result waits in the output register; the next request is taken meanwhile.
`default_nettype none

module stack_with_search
  import sws_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [WORD_W-1:0]     s_tdata,   // [31:0] operand
  input  wire logic [OPCODE_W-1:0]   s_tuser,   // [1:0] opcode
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // [31:0] result_value, [38:32] position
  output logic [STATUS_W-1:0]        m_tuser    // [1:0] status
);

  localparam int AW = $clog2(DEPTH);

  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  word_t         mem_wdata;
  word_t         mem_rdata;
  word_t         out_value;
  pos_t          out_pos;
  status_t       out_status;

  sws_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_opcode  (s_tuser),
    .in_operand (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_value  (out_value),
    .out_pos    (out_pos),
    .out_status (out_status),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  sws_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign m_tdata = {{(OUT_DATA_W - WORD_W - POS_W){1'b0}}, out_pos, out_value};
  assign m_tuser = out_status;

endmodule

`default_nettype wire

// ===== sv/sws_mem.sv =====
// Stack word storage: one write port, one read port with registered read data.
// Depends on sws_pkg for the word type.
`default_nettype none

module sws_mem
  import sws_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire word_t         wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output word_t              rdata
);

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/sws_ctrl.sv =====
// Stack sequencer: entry count, request decode, top-down search scan, result register.
// Depends on sws_pkg and drives the sws_mem ports.
`default_nettype none
`include "stack_with_search_defines.svh"

module sws_ctrl
  import sws_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire opcode_t       in_opcode,
  input  wire word_t         in_operand,
  output logic               out_valid,
  input  wire logic          out_ready,
  output word_t              out_value,
  output pos_t               out_pos,
  output status_t            out_status,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output word_t              mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  wire word_t         mem_rdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [AW-1:0] cur_addr;
  word_t         key;
  logic          op_pop;
  word_t         res_value;
  pos_t          res_pos;
  status_t       res_status;

  logic          s_fire;
  logic          full;
  logic          empty;
  logic          hit;
  logic [AW-1:0] top_addr;
  logic [CW-1:0] count_dec;

  assign in_ready  = (state == S_IDLE);
  assign s_fire    = in_valid && in_ready;
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign count_dec = count - CW'(1);
  assign top_addr  = count_dec[AW-1:0];
  assign hit       = (mem_rdata == key);

  // One item at a time: a write happens only when a push is accepted, reads only when another
  // request is accepted or during the scan, so the same entry is never written and read in one cycle.
  assign mem_we    = s_fire && (in_opcode == OP_PUSH) && !full;
  assign mem_waddr = count[AW-1:0];
  assign mem_wdata = in_operand;
  assign mem_re    = (s_fire && (in_opcode != OP_PUSH) && !empty) || (state == S_SCAN);
  assign mem_raddr = (state == S_SCAN) ? (cur_addr - AW'(1)) : top_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the beat once taken, unless a new result loads this cycle
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            key        <= in_operand;
            op_pop     <= (in_opcode == OP_POP);
            idx        <= CW'(1);
            cur_addr   <= top_addr;
            res_value  <= '0;
            res_pos    <= '0;
            unique case (in_opcode)
              OP_PUSH: begin
                if (full) begin
                  res_status <= ST_OVERFLOW;
                end else begin
                  res_status <= ST_OK;
                  count      <= count + CW'(1);
                end
                state <= S_DONE;
              end
              OP_POP, OP_PEEK: begin
                if (empty) begin
                  res_status <= ST_UNDERFLOW;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_READ;
                end
              end
              OP_SEARCH: begin
                if (empty) begin
                  res_status <= ST_UNDERFLOW;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_OK;
                  state      <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_READ: begin
          res_value <= mem_rdata;
          if (op_pop) begin
            count <= count_dec;
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          // rdata holds the entry at depth idx; stop on a match or at the bottom
          if (hit) begin
            res_pos <= POS_W'(idx);
            state   <= S_DONE;
          end else if (cur_addr == '0) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_DONE;
          end else begin
            cur_addr <= cur_addr - AW'(1);
            idx      <= idx + CW'(1);
          end
        end
        S_DONE: begin
          // hold the result until the output register frees up
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            out_value  <= res_value;
            out_pos    <= res_pos;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
      endcase
    end
  end

  `SWS_ASSERT(a_count_bound, count <= CW'(DEPTH), "entry count exceeds depth")
  `SWS_ASSERT(a_no_wr_rd_overlap, !(mem_we && mem_re), "write and read in the same cycle")
  `SWS_ASSERT(a_scan_in_range, (state != S_SCAN) || (idx <= count && idx != '0),
              "scan depth outside the stored entries")
  `SWS_ASSERT_NEXT(a_push_grows, s_fire && (in_opcode == OP_PUSH) && !full,
                   count == $past(count) + CW'(1), "push did not grow the stack")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for stack_with_search: streams push, pop, peek and search
// requests with random gaps and result stalls and checks every result beat.
// Depends on sws_pkg and the stack_with_search RTL.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sws_pkg::*;

  localparam int STACK_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 360;
  localparam int MAX_GAP      = 12;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 2 * STACK_DEPTH + 8;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    opcode_t op;
    word_t   word;
  } request_t;

  typedef struct packed {
    word_t   value;
    pos_t    pos;
    status_t status;
  } reply_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [WORD_W-1:0]     s_tdata  = '0;
  logic [OPCODE_W-1:0]   s_tuser  = OP_PUSH;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  stack_with_search #(
    .DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Request stream and the generator's view of the stack contents
  request_t pending_q[$];
  word_t    gen_stack[$];
  int       n_queued = 0;
  int       n_pushes = 0;

  // Expected stack contents, updated as requests are accepted
  word_t       stk_mem [STACK_DEPTH];
  int unsigned stk_cnt = 0;
  reply_t      reply_q[$];

  bit       req_taken = 1'b0;
  bit       res_taken = 1'b0;
  int       req_wait = 0;
  int       res_wait = 0;
  int       src_calm = 0;
  int       sink_calm = 0;
  request_t next_req;
  reply_t   want;
  logic [OUT_DATA_W-1:0] want_data;

  int n_accepted = 0;
  int n_checked  = 0;
  int n_errors   = 0;
  int n_overflow = 0;
  int n_underflow = 0;
  int n_not_found = 0;
  int deepest    = 0;
  int idle_cycles = 0;

  function automatic reply_t apply_request(request_t req);
    reply_t      r;
    bit          hit;
    int unsigned d;
    r = '0;
    r.status = ST_OK;
    case (req.op)
      OP_PUSH: begin
        if (stk_cnt >= STACK_DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          stk_mem[stk_cnt] = req.word;
          stk_cnt++;
        end
      end
      OP_POP, OP_PEEK: begin
        if (stk_cnt == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.value = stk_mem[stk_cnt-1];
          if (req.op == OP_POP) stk_cnt--;
        end
      end
      default: begin
        if (stk_cnt == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          hit = 1'b0;
          // scan from the top, stop at the first match
          for (d = 1; d <= stk_cnt && !hit; d++) begin
            if (stk_mem[stk_cnt-d] == req.word) begin
              hit = 1'b1;
              r.pos = pos_t'(d);
            end
          end
          if (!hit) r.status = ST_NOT_FOUND;
        end
      end
    endcase
    return r;
  endfunction

  // Mostly random gaps, with occasional stretches of back-to-back beats
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic add_req(opcode_t op, word_t word);
    pending_q.push_back(request_t'{op: op, word: word});
    n_queued++;
    case (op)
      OP_PUSH: begin
        n_pushes++;
        if (gen_stack.size() < STACK_DEPTH) gen_stack.push_back(word);
      end
      OP_POP: begin
        if (gen_stack.size() > 0) void'(gen_stack.pop_back());
      end
      default: ;
    endcase
  endtask

  // Random word, or one from a small pool of corner values so that duplicates land on the stack
  function automatic word_t pick_word();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 5))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        3: return 32'hffff_ffff;
        4: return 32'h0000_0001;
        default: return 32'h5a5a_a5a5;
      endcase
    end
    return $urandom();
  endfunction

  function automatic word_t search_word();
    if (gen_stack.size() > 0 && $urandom_range(0, 9) < 7)
      return gen_stack[$urandom_range(0, gen_stack.size() - 1)];
    return pick_word();
  endfunction

  // Request driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (req_wait > 0) begin
        req_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        next_req = pending_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_req.word;
        s_tuser  <= next_req.op;
        req_wait = draw_gap(src_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result stall: hold ready low for a drawn number of cycles after each beat
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (res_taken) res_wait = draw_gap(sink_calm);
      if (res_wait > 0) begin
        res_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor, result check and watchdog
  always @(posedge clk) begin
    if (rst) begin
      req_taken = 1'b0;
      res_taken = 1'b0;
    end else begin
      req_taken = s_tvalid && s_tready;
      res_taken = m_tvalid && m_tready;
      if (req_taken) begin
        reply_q.push_back(apply_request(request_t'{op: s_tuser, word: s_tdata}));
        n_accepted++;
      end
      if (res_taken) begin
        if (reply_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("[%0t] unexpected result beat: tdata=%h tuser=%0d",
                     $realtime, m_tdata, m_tuser);
        end else begin
          want = reply_q.pop_front();
          n_checked++;
          want_data = {1'b0, want.pos, want.value};
          if (m_tdata !== want_data || m_tuser !== want.status) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("[%0t] result %0d: want %h/%0d/%0d got %h/%0d/%0d pad %b",
                       $realtime, n_checked, want.value, want.pos, want.status,
                       m_tdata[31:0], m_tdata[38:32], m_tuser, m_tdata[39]);
          end
          case (want.status)
            ST_OVERFLOW:  n_overflow++;
            ST_UNDERFLOW: n_underflow++;
            ST_NOT_FOUND: n_not_found++;
            default: if (int'(want.pos) > deepest) deepest = int'(want.pos);
          endcase
        end
      end
      idle_cycles = (req_taken || res_taken) ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles, %0d of %0d results seen",
                 IDLE_LIMIT, n_checked, n_queued);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int rand_start;

    // Empty stack: every read and search underflows
    add_req(OP_POP, 32'hffff_ffff);
    add_req(OP_PEEK, 32'h0000_0000);
    add_req(OP_SEARCH, 32'h0000_0000);
    // Extreme words, one duplicated so search must report the top copy
    add_req(OP_PUSH, 32'h8000_0000);
    add_req(OP_PUSH, 32'h7fff_ffff);
    add_req(OP_PUSH, 32'h0000_0000);
    add_req(OP_PUSH, 32'hffff_ffff);
    add_req(OP_PUSH, 32'h8000_0000);
    add_req(OP_PEEK, 32'h1234_5678);
    add_req(OP_SEARCH, 32'h8000_0000);
    add_req(OP_SEARCH, 32'h7fff_ffff);
    add_req(OP_SEARCH, 32'h1234_5678);
    add_req(OP_SEARCH, 32'hffff_ffff);
    add_req(OP_POP, 32'h0000_0000);
    add_req(OP_SEARCH, 32'h8000_0000);
    add_req(OP_POP, 32'h0000_0000);
    add_req(OP_POP, 32'h0000_0000);
    add_req(OP_POP, 32'h0000_0000);
    add_req(OP_POP, 32'h0000_0000);
    add_req(OP_POP, 32'h0000_0000);
    add_req(OP_PUSH, 32'h0000_0001);
    add_req(OP_SEARCH, 32'h0000_0001);
    add_req(OP_POP, 32'h0000_0000);

    rand_start = n_queued;
    while (n_queued - rand_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // fill to the top, then push into a full stack and search it
          while (gen_stack.size() < STACK_DEPTH) begin
            if ($urandom_range(0, 7) == 0) begin
              if ($urandom_range(0, 1)) add_req(OP_PEEK, $urandom());
              else add_req(OP_SEARCH, search_word());
            end else begin
              add_req(OP_PUSH, pick_word());
            end
          end
          repeat ($urandom_range(1, 3)) add_req(OP_PUSH, pick_word());
          repeat ($urandom_range(1, 4)) add_req(OP_SEARCH, search_word());
        end
        3, 4: begin
          // drain to empty, then poke the empty stack
          while (gen_stack.size() > 0) begin
            if ($urandom_range(0, 7) == 0) add_req(OP_SEARCH, search_word());
            else add_req(OP_POP, $urandom());
          end
          repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 2))
              0: add_req(OP_POP, $urandom());
              1: add_req(OP_PEEK, $urandom());
              default: add_req(OP_SEARCH, $urandom());
            endcase
          end
        end
        default: begin
          repeat (16) begin
            case ($urandom_range(0, 19))
              0, 1, 2, 3, 4, 5, 6: add_req(OP_PUSH, pick_word());
              7, 8, 9, 10, 11: add_req(OP_POP, $urandom());
              12, 13, 14: add_req(OP_PEEK, $urandom());
              default: add_req(OP_SEARCH, search_word());
            endcase
          end
        end
      endcase
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (n_accepted == n_queued);
    wait (n_checked == n_queued);
    repeat (TAIL_CYCLES) @(posedge clk);
    n_errors += reply_q.size();

    $display("Checked %0d results for %0d requests (%0d pushes), %0d mismatching beats",
             n_checked, n_queued, n_pushes, n_errors);
    $display("Overflow %0d, underflow %0d, not found %0d, deepest match %0d of %0d",
             n_overflow, n_underflow, n_not_found, deepest, STACK_DEPTH);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/sws_pkg.sv
sv/sws_mem.sv
sv/sws_ctrl.sv
sv/stack_with_search.sv
tb/tb.sv
